### design/mdd_pkg.sv
// Max drawdown tracker package: shared widths, defaults and the queue control word.
// Used by mdd_front, mdd_fifo, mdd_back and max_drawdown_tracker.
package mdd_pkg;

	localparam int VALUE_WIDTH_DEF     = 48;
	localparam int DEPTH_FRAC_BITS_DEF = 24;
	localparam int DAY_WIDTH           = 24;
	localparam int DEPTH_WIDTH         = 32;
	localparam int QUEUE_DEPTH         = 2;
	localparam int DIV_STEPS           = DEPTH_WIDTH;
	localparam int STEP_CNT_WIDTH      = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                 first;
		logic                 div_en;
		logic                 below;
		logic [DAY_WIDTH-1:0] days;
	} mdd_ctl_t;

	localparam int CTL_WIDTH = $bits(mdd_ctl_t);

endpackage

### design/max_drawdown_tracker.sv
// Max drawdown tracker: peak/day tracking per equity point, worst depth and duration.
// Top level; instantiates mdd_front, mdd_fifo and mdd_back. Depends on mdd_pkg.
//
// Each accepted point yields one result: the worst drawdown fraction so far in
// unsigned Q8.24 (saturating), the longest drawdown in days with an open one
// counted to the current day, and whether the point lies below the running
// peak. A point below a positive peak that does not saturate takes a load, 32
// steps of the radix-2 restoring divider and a result load in the back end;
// any other point skips the steps. The divider sets the sustained rate. The
// front end accepts points immediately while the two-entry queue has room, so
// up to two points may be taken ahead of the one being divided, and a finished
// result waits in the output register without blocking the next division.
module max_drawdown_tracker #(
	parameter int VALUE_WIDTH     = mdd_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH_FRAC_BITS = mdd_pkg::DEPTH_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              first_point,
	input  logic signed [VALUE_WIDTH-1:0]     equity_value,
	input  logic [mdd_pkg::DAY_WIDTH-1:0]     day_number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mdd_pkg::DEPTH_WIDTH-1:0]   max_depth,
	output logic [mdd_pkg::DAY_WIDTH-1:0]     max_days,
	output logic                              in_drawdown
);

	localparam int EntryWidth = mdd_pkg::CTL_WIDTH + 2 * VALUE_WIDTH;

	logic                      push_valid;
	logic                      push_ready;
	mdd_pkg::mdd_ctl_t         push_ctl;
	logic [VALUE_WIDTH-1:0]    push_diff;
	logic [VALUE_WIDTH-1:0]    push_den;
	logic                      q_valid;
	logic                      q_ready;
	logic [EntryWidth-1:0]     q_data;
	mdd_pkg::mdd_ctl_t         q_ctl;
	logic [VALUE_WIDTH-1:0]    q_diff;
	logic [VALUE_WIDTH-1:0]    q_den;

	assign q_ctl  = q_data[EntryWidth-1 -: mdd_pkg::CTL_WIDTH];
	assign q_diff = q_data[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
	assign q_den  = q_data[VALUE_WIDTH-1:0];

	mdd_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_point  (first_point),
		.equity_value (equity_value),
		.day_number   (day_number),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_ctl     (push_ctl),
		.push_diff    (push_diff),
		.push_den     (push_den)
	);

	mdd_fifo #(
		.WIDTH (EntryWidth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  ({push_ctl, push_diff, push_den}),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	mdd_back #(
		.VALUE_WIDTH     (VALUE_WIDTH),
		.DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_ctl       (q_ctl),
		.q_diff      (q_diff),
		.q_den       (q_den),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.max_depth   (max_depth),
		.max_days    (max_days),
		.in_drawdown (in_drawdown)
	);

endmodule

### design/mdd_front.sv
// Front end: accepts equity points, keeps the running peak and day state,
// classifies each beat and pushes it, with its divide operands, into the queue. Depends on mdd_pkg.
module mdd_front #(
	parameter int VALUE_WIDTH = mdd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                first_point,
	input  logic signed [VALUE_WIDTH-1:0]       equity_value,
	input  logic [mdd_pkg::DAY_WIDTH-1:0]       day_number,
	output logic                                push_valid,
	input  logic                                push_ready,
	output mdd_pkg::mdd_ctl_t                   push_ctl,
	output logic [VALUE_WIDTH-1:0]              push_diff,
	output logic [VALUE_WIDTH-1:0]              push_den
);

	logic signed [VALUE_WIDTH-1:0]        peak_q;
	logic [mdd_pkg::DAY_WIDTH-1:0]        peak_day_q;
	logic                                 below_q;
	logic [mdd_pkg::DAY_WIDTH-1:0]        worst_days_q;

	logic                                 accept;
	logic                                 lt;
	logic                                 peak_pos;
	logic [mdd_pkg::DAY_WIDTH-1:0]        span;
	logic [mdd_pkg::DAY_WIDTH-1:0]        span_max;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_comb begin
		lt       = equity_value < peak_q;
		peak_pos = !peak_q[VALUE_WIDTH-1] && (|peak_q);
		span     = (day_number >= peak_day_q) ? (day_number - peak_day_q) : '0;
		span_max = (span > worst_days_q) ? span : worst_days_q;

		push_ctl.first  = first_point;
		push_ctl.below  = !first_point && lt;
		push_ctl.div_en = !first_point && lt && peak_pos;
		if (first_point) begin
			push_ctl.days = '0;
		end else if (below_q || lt) begin
			push_ctl.days = span_max;
		end else begin
			push_ctl.days = worst_days_q;
		end
		push_diff = VALUE_WIDTH'(peak_q - equity_value);
		push_den  = peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q       <= '0;
			peak_day_q   <= '0;
			below_q      <= 1'b0;
			worst_days_q <= '0;
		end else if (accept) begin
			if (first_point) begin
				peak_q       <= equity_value;
				peak_day_q   <= day_number;
				below_q      <= 1'b0;
				worst_days_q <= '0;
			end else if (!lt) begin
				if (below_q) begin
					worst_days_q <= span_max;
				end
				below_q    <= 1'b0;
				peak_q     <= equity_value;
				peak_day_q <= day_number;
			end else begin
				below_q <= 1'b1;
			end
		end
	end

endmodule

### design/mdd_fifo.sv
// Two-entry queue between the front end and the divider back end.
// Depends on mdd_pkg.
module mdd_fifo #(
	parameter int WIDTH = mdd_pkg::CTL_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PtrWidth = (mdd_pkg::QUEUE_DEPTH > 1) ? $clog2(mdd_pkg::QUEUE_DEPTH) : 1;
	localparam int CntWidth = $clog2(mdd_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [mdd_pkg::QUEUE_DEPTH];
	logic [PtrWidth-1:0] wr_ptr_q;
	logic [PtrWidth-1:0] rd_ptr_q;
	logic [CntWidth-1:0] count_q;
	logic                push;
	logic                pop;

	assign wr_ready = count_q != CntWidth'(mdd_pkg::QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrWidth'(mdd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrWidth'(mdd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### design/mdd_back.sv
// Back end: radix-2 restoring divider for the drawdown fraction, worst-depth
// update and the output register. Depends on mdd_pkg.
module mdd_back #(
	parameter int VALUE_WIDTH     = mdd_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH_FRAC_BITS = mdd_pkg::DEPTH_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  mdd_pkg::mdd_ctl_t                 q_ctl,
	input  logic [VALUE_WIDTH-1:0]            q_diff,
	input  logic [VALUE_WIDTH-1:0]            q_den,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mdd_pkg::DEPTH_WIDTH-1:0]   max_depth,
	output logic [mdd_pkg::DAY_WIDTH-1:0]     max_days,
	output logic                              in_drawdown
);

	localparam int DW = VALUE_WIDTH + mdd_pkg::DEPTH_WIDTH;
	localparam int QW = mdd_pkg::DEPTH_WIDTH;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_DONE
	} state_t;

	state_t                                state_q;
	mdd_pkg::mdd_ctl_t                     ctl_q;
	logic [VALUE_WIDTH-1:0]                den_q;
	logic [VALUE_WIDTH-1:0]                rem_q;
	logic [QW-1:0]                         low_q;
	logic [mdd_pkg::STEP_CNT_WIDTH-1:0]    cnt_q;
	logic [QW-1:0]                         worst_q;
	logic [QW-1:0]                         depth_q;
	logic [mdd_pkg::DAY_WIDTH-1:0]         days_q;
	logic                                  dd_q;
	logic                                  out_valid_q;

	logic                                  pop;
	logic                                  load;
	logic [DW-1:0]                         dividend;
	logic [VALUE_WIDTH-1:0]                r_init;
	logic                                  sat;
	logic [VALUE_WIDTH:0]                  r2;
	logic [VALUE_WIDTH:0]                  r_sub;
	logic                                  step_bit;
	logic [VALUE_WIDTH-1:0]                step_rem;
	logic [QW-1:0]                         new_worst;

	assign q_ready     = state_q == S_IDLE;
	assign pop         = q_valid && q_ready;
	assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign max_depth   = depth_q;
	assign max_days    = days_q;
	assign in_drawdown = dd_q;

	always_comb begin
		dividend = {{QW{1'b0}}, q_diff} << DEPTH_FRAC_BITS;
		r_init   = dividend[DW-1:QW];
		sat      = r_init >= q_den;
		r2       = {rem_q, low_q[QW-1]};
		r_sub    = r2 - {1'b0, den_q};
		step_bit = r2 >= {1'b0, den_q};
		step_rem = step_bit ? r_sub[VALUE_WIDTH-1:0] : r2[VALUE_WIDTH-1:0];
		if (ctl_q.first) begin
			new_worst = '0;
		end else if (ctl_q.div_en && (low_q > worst_q)) begin
			new_worst = low_q;
		end else begin
			new_worst = worst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ctl_q       <= '0;
			den_q       <= '0;
			rem_q       <= '0;
			low_q       <= '0;
			cnt_q       <= '0;
			worst_q     <= '0;
			depth_q     <= '0;
			days_q      <= '0;
			dd_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						ctl_q <= q_ctl;
						den_q <= q_den;
						rem_q <= r_init;
						cnt_q <= '1;
						if (q_ctl.div_en && sat) begin
							low_q <= '1;
						end else begin
							low_q <= dividend[QW-1:0];
						end
						if (q_ctl.div_en && !sat) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIV: begin
					rem_q <= step_rem;
					low_q <= {low_q[QW-2:0], step_bit};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load) begin
						worst_q     <= new_worst;
						depth_q     <= new_worst;
						days_q      <= ctl_q.days;
						dd_q        <= ctl_q.below;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |=> state_q == S_DONE)
		else $error("divider did not finish after last step");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("result load did not raise out_valid");

	a_depth_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !ctl_q.first) |=> depth_q >= $past(worst_q))
		else $error("worst depth decreased without a new series");

	a_no_div_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !q_ctl.div_en) |=> state_q == S_DONE)
		else $error("beat without divide entered the divider");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for max_drawdown_tracker: directed equity points, then random series, with
// each result checked against its table entry or a running peak / drawdown predictor. Depends on mdd_pkg.
module tb;

	localparam int VW          = mdd_pkg::VALUE_WIDTH_DEF;
	localparam int FRAC        = mdd_pkg::DEPTH_FRAC_BITS_DEF;
	localparam int DW          = mdd_pkg::DAY_WIDTH;
	localparam int QW          = mdd_pkg::DEPTH_WIDTH;
	localparam int TOTAL_ITEMS = 1750;
	localparam int STEADY_TAIL = 200;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 80;

	typedef struct packed {
		logic [QW-1:0] depth;
		logic [DW-1:0] days;
		logic          dd;
	} drawdown_t;

	typedef struct packed {
		logic          fp;
		logic [VW-1:0] value;
		logic [DW-1:0] day;
		logic          typed;
		drawdown_t     want;
	} point_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic          first_point = 1'b0;
	logic [VW-1:0] equity_value = '0;
	logic [DW-1:0] day_number = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [QW-1:0] max_depth;
	logic [DW-1:0] max_days;
	logic          in_drawdown;

	logic signed [VW-1:0] pk_value = '0;
	logic [DW-1:0]        pk_day = '0;
	logic                 open_dd = 1'b0;
	logic [QW-1:0]        worst_depth = '0;
	logic [DW-1:0]        worst_days = '0;

	drawdown_t pending_results[$];
	drawdown_t head;
	int        n_errors = 0;
	int        n_sent = 0;
	int        idle_cycles = 0;
	logic      steady = 1'b0;

	point_row_t dir_rows [22] = '{
		'{1'b0, 48'd0,              24'd0,        1'b1, '{32'h0,        24'd0,        1'b0}},
		'{1'b0, -48'sd5,            24'd3,        1'b1, '{32'h0,        24'd3,        1'b1}},
		'{1'b0, -48'sd5,            24'd2,        1'b0, '0},
		'{1'b1, 48'd1000,           24'd10,       1'b1, '0},
		'{1'b0, 48'd750,            24'd12,       1'b1, '{32'h00400000, 24'd2,        1'b1}},
		'{1'b0, 48'd1000,           24'd15,       1'b1, '{32'h00400000, 24'd5,        1'b0}},
		'{1'b0, 48'd900,            24'd14,       1'b0, '0},
		'{1'b0, 48'd2000,           24'd13,       1'b0, '0},
		'{1'b1, 48'h7FFF_FFFF_FFFF, 24'd0,        1'b1, '0},
		'{1'b0, 48'h8000_0000_0000, 24'hFFFFFF,   1'b1, '{32'h02000000, 24'hFFFFFF,   1'b1}},
		'{1'b1, 48'd1,              24'd5,        1'b1, '0},
		'{1'b0, 48'h8000_0000_0000, 24'd6,        1'b1, '{32'hFFFFFFFF, 24'd1,        1'b1}},
		'{1'b1, -48'sd100,          24'd0,        1'b1, '0},
		'{1'b0, -48'sd200,          24'd7,        1'b1, '{32'h0,        24'd7,        1'b1}},
		'{1'b0, -48'sd50,           24'd9,        1'b0, '0},
		'{1'b1, 48'd0,              24'd100,      1'b1, '0},
		'{1'b0, -48'sd1,            24'd200,      1'b0, '0},
		'{1'b0, 48'h5555_5555_5555, 24'h555555,   1'b0, '0},
		'{1'b0, 48'hAAAA_AAAA_AAAA, 24'hAAAAAA,   1'b0, '0},
		'{1'b1, 48'd1,              24'd0,        1'b1, '0},
		'{1'b0, 48'd0,              24'd0,        1'b1, '{32'h01000000, 24'd0,        1'b1}},
		'{1'b0, 48'd1,              24'hFFFFFF,   1'b1, '{32'h01000000, 24'hFFFFFF,   1'b0}}
	};

	max_drawdown_tracker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.first_point (first_point),
		.equity_value(equity_value),
		.day_number  (day_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.max_depth   (max_depth),
		.max_days    (max_days),
		.in_drawdown (in_drawdown)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [DW-1:0] days_since(input logic [DW-1:0] from,
		input logic [DW-1:0] to);
		return (to >= from) ? to - from : '0;
	endfunction

	// advance the peak and drawdown state by one point and return its result
	function automatic drawdown_t track_point(input logic fp, input logic signed [VW-1:0] value,
		input logic [DW-1:0] day);
		drawdown_t      r;
		logic [VW-1:0]  diff;
		logic [2*VW-1:0] quot;
		logic [DW-1:0]  span;
		if (fp) begin
			pk_value = value;
			pk_day = day;
			open_dd = 1'b0;
			worst_depth = '0;
			worst_days = '0;
		end else if (value >= pk_value) begin
			if (open_dd) begin
				span = days_since(pk_day, day);
				if (span > worst_days)
					worst_days = span;
				open_dd = 1'b0;
			end
			pk_value = value;
			pk_day = day;
		end else begin
			open_dd = 1'b1;
			if (pk_value > 0) begin
				diff = pk_value - value;
				quot = ({{VW{1'b0}}, diff} << FRAC) / {{VW{1'b0}}, pk_value};
				if (quot > {{(2*VW-QW){1'b0}}, {QW{1'b1}}})
					quot = {{(2*VW-QW){1'b0}}, {QW{1'b1}}};
				if (quot[QW-1:0] > worst_depth)
					worst_depth = quot[QW-1:0];
			end
		end
		r.depth = worst_depth;
		r.days = worst_days;
		if (open_dd) begin
			span = days_since(pk_day, day);
			if (span > r.days)
				r.days = span;
		end
		r.dd = open_dd;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [QW-1:0] got,
		input logic [QW-1:0] want);
		$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
		n_errors++;
	endtask

	task automatic send_point(input logic fp, input logic [VW-1:0] value, input logic [DW-1:0] day,
		input logic typed, input drawdown_t typed_result);
		drawdown_t predicted;
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_point <= fp;
		equity_value <= value;
		day_number <= day;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = track_point(fp, value, day);
		if (typed)
			predicted = typed_result;
		pending_results = {pending_results, predicted};
		n_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", max_depth, '0);
			end else begin
				head = pending_results.pop_front();
				if (max_depth !== head.depth)
					report_mismatch("max_depth", max_depth, head.depth);
				if (max_days !== head.days)
					report_mismatch("max_days", QW'(max_days), QW'(head.days));
				if (in_drawdown !== head.dd)
					report_mismatch("in_drawdown", QW'(in_drawdown), QW'(head.dd));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!steady && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	initial begin
		logic signed [63:0] val;
		logic signed [63:0] mag;
		logic [63:0]        r64;
		logic [DW-1:0]      day;
		int                 kind;
		int                 series_len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_point(dir_rows[i].fp, dir_rows[i].value, dir_rows[i].day, dir_rows[i].typed,
				dir_rows[i].want);
		while (n_sent < TOTAL_ITEMS) begin
			kind = $urandom_range(0, 15);
			r64 = {$urandom, $urandom};
			if (kind == 0) begin
				send_point(1'($urandom_range(0, 1)), r64[VW-1:0], DW'($urandom), 1'b0, '0);
			end else begin
				series_len = $urandom_range(2, 40);
				val = r64 >> $urandom_range(17, 56);
				if (kind == 1)
					val = -val;
				day = (kind == 2) ? DW'(24'hFFFFFF - $urandom_range(0, 200)) : DW'($urandom);
				send_point(kind != 3, val[VW-1:0], day, 1'b0, '0);
				for (int j = 1; j < series_len && n_sent < TOTAL_ITEMS; j++) begin
					steady = (n_sent >= TOTAL_ITEMS - STEADY_TAIL);
					val = 64'(pk_value);
					mag = (val < 0) ? -val : val;
					mag = (mag >> $urandom_range(1, 8)) + 1;
					r64 = {$urandom, $urandom};
					case ($urandom_range(0, 7))
						0: val = 64'(pk_value);
						1, 2: val = 64'(pk_value) + r64 % mag;
						7: val = {{(64-VW){r64[VW-1]}}, r64[VW-1:0]};
						default: val = 64'(pk_value) - r64 % mag;
					endcase
					day = day + DW'($urandom_range(0, 9));
					if ($urandom_range(0, 31) == 0)
						day = day - DW'($urandom_range(1, 20));
					send_point(1'b0, val[VW-1:0], day, 1'b0, '0);
				end
			end
			steady = (n_sent >= TOTAL_ITEMS - STEADY_TAIL);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
